>>> sv/imu_packet_sync_and_extract_defines.svh
// Assertion macros for the IMU packet sync and extract block.
// Used by the top level; expects signals named clk and rst_n in scope.
`ifndef IMU_PACKET_SYNC_AND_EXTRACT_DEFINES_SVH
`define IMU_PACKET_SYNC_AND_EXTRACT_DEFINES_SVH

// Checked only while out of reset.
`define IPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define IPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/ips_pkg.sv
// Shared types and constants for the IMU packet sync and extract block.
// No dependencies.
`timescale 1ns / 1ps

package ips_pkg;

    localparam int PACKET_BYTES  = 79;
    localparam int SUM_BYTES     = PACKET_BYTES - 2;
    localparam int TIMER_POS     = PACKET_BYTES - 6;
    localparam int PAYLOAD_WORDS = 18;

    localparam logic [7:0] HEADER_RESET = 8'hCC;
    localparam logic [4:0] WORD_DELTA   = 5'(PAYLOAD_WORDS);

    typedef logic [7:0]  byte_t;
    typedef logic [31:0] word_t;
    typedef logic [4:0]  word_index_t;

    typedef struct packed {
        logic [PAYLOAD_WORDS-1:0][31:0] words;
        word_t                          delta;
    } pkt_t;

endpackage

>>> sv/ips_front.sv
// Front end: byte window, running sum, header and checksum test, timer delta.
// Depends on ips_pkg.
`timescale 1ns / 1ps

module ips_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata,
    input  logic          in_valid,
    input  logic [7:0]    in_byte,
    input  logic          push_ready,
    output logic          push,
    output ips_pkg::pkt_t pkt
);
    import ips_pkg::*;

    byte_t        window_reg [PACKET_BYTES];
    logic [6:0]   fill_reg;
    logic [15:0]  sum_reg;
    logic [15:0]  sum_next;
    word_t        prev_timer_reg;
    byte_t        header_reg;
    word_t        timer;
    logic         full_next;
    logic         hit;
    logic         accept;

    assign accept = in_valid && push_ready;

    always_comb
    begin
        sum_next  = sum_reg - 16'(window_reg[0]) + 16'(window_reg[SUM_BYTES]);
        full_next = (fill_reg >= 7'(PACKET_BYTES - 1));
        hit       = full_next && (window_reg[1] == header_reg) &&
                    (sum_next == {window_reg[PACKET_BYTES-1], in_byte});
        for (int k = 0; k < PAYLOAD_WORDS; k++)
        begin
            pkt.words[k] = {window_reg[2+4*k], window_reg[3+4*k],
                            window_reg[4+4*k], window_reg[5+4*k]};
        end
        timer     = {window_reg[TIMER_POS+1], window_reg[TIMER_POS+2],
                     window_reg[TIMER_POS+3], window_reg[TIMER_POS+4]};
        pkt.delta = timer - prev_timer_reg;
    end

    assign push = accept && hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PACKET_BYTES; i++)
            begin
                window_reg[i] <= '0;
            end
            fill_reg       <= '0;
            sum_reg        <= '0;
            prev_timer_reg <= '0;
            header_reg     <= HEADER_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                header_reg <= cfg_wdata;
            end
            if (accept)
            begin
                if (hit)
                begin
                    for (int i = 0; i < PACKET_BYTES; i++)
                    begin
                        window_reg[i] <= '0;
                    end
                    fill_reg       <= '0;
                    sum_reg        <= '0;
                    prev_timer_reg <= timer;
                end
                else
                begin
                    for (int i = 0; i < PACKET_BYTES - 1; i++)
                    begin
                        window_reg[i] <= window_reg[i+1];
                    end
                    window_reg[PACKET_BYTES-1] <= in_byte;
                    fill_reg <= full_next ? 7'(PACKET_BYTES) : fill_reg + 7'd1;
                    sum_reg  <= sum_next;
                end
            end
        end
    end

endmodule

>>> sv/ips_queue.sv
// One-entry packet queue between the front end and the back end.
// Depends on ips_pkg.
`timescale 1ns / 1ps

module ips_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  ips_pkg::pkt_t in_pkt,
    output logic          in_ready,
    output logic          out_valid,
    output ips_pkg::pkt_t out_pkt,
    input  logic          out_ready
);
    import ips_pkg::*;

    logic full_reg;
    pkt_t pkt_reg;

    assign in_ready  = !full_reg || out_ready;
    assign out_valid = full_reg;
    assign out_pkt   = pkt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            full_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pkt_reg <= in_pkt;
        end
    end

endmodule

>>> sv/ips_back.sv
// Back end: walks one packet out as 18 payload words and the timer delta.
// Depends on ips_pkg.
`timescale 1ns / 1ps

module ips_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pkt_valid,
    input  ips_pkg::pkt_t pkt,
    output logic          pkt_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [4:0]    out_index,
    output logic [31:0]   out_data,
    output logic          out_last
);
    import ips_pkg::*;

    logic                           busy_reg;
    word_index_t                    count_reg;
    logic [PAYLOAD_WORDS-1:0][31:0] words_reg;
    word_t                          delta_reg;
    logic                           out_valid_reg;
    word_index_t                    out_index_reg;
    word_t                          out_data_reg;
    logic                           out_last_reg;
    logic                           adv;
    logic                           at_delta;

    assign pkt_ready = !busy_reg;
    assign adv       = !out_valid_reg || out_ready;
    assign at_delta  = (count_reg == WORD_DELTA);

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= busy_reg;
            end
            if (pkt_valid && !busy_reg)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg && adv)
            begin
                count_reg <= count_reg + 5'd1;
                if (at_delta)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_valid && !busy_reg)
        begin
            words_reg <= pkt.words;
            delta_reg <= pkt.delta;
        end
        else if (busy_reg && adv)
        begin
            words_reg <= words_reg >> 32;
        end
        if (adv && busy_reg)
        begin
            out_index_reg <= count_reg;
            out_data_reg  <= at_delta ? delta_reg : words_reg[0];
            out_last_reg  <= at_delta;
        end
    end

endmodule

>>> sv/imu_packet_sync_and_extract.sv
// Top level of the IMU packet sync and extract block.
// Depends on ips_pkg, ips_front, ips_queue, ips_back and the defines header.
//
//  Channel   Direction  Handshake                       Content
//  s_axis    in         s_axis_tvalid / s_axis_tready   one received byte
//  m_axis    out        m_axis_tvalid / m_axis_tready   one word of a found packet
//  cfg       in         cfg_we                          header byte
//
// One byte is taken per cycle; the window shift, sum update and checksum
// compare all finish in the accepting cycle.
// A found packet yields 19 results, one per cycle while m_axis_tready is high, from the back-end shift line.
// Reset zeroes the window, count, sum and previous timer; no clearing pass.
// The input stalls only while one packet waits in the queue and another is
// still being sent.
`timescale 1ns / 1ps
`include "imu_packet_sync_and_extract_defines.svh"

module imu_packet_sync_and_extract (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] data_word
    output logic [4:0]  m_axis_tuser,   // [4:0] word_index
    output logic        m_axis_tlast
);
    import ips_pkg::*;

    logic push;
    logic push_ready;
    pkt_t front_pkt;
    logic q_valid;
    logic q_ready;
    pkt_t q_pkt;

    ips_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata),
        .push_ready (push_ready),
        .push       (push),
        .pkt        (front_pkt)
    );

    ips_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push),
        .in_pkt    (front_pkt),
        .in_ready  (push_ready),
        .out_valid (q_valid),
        .out_pkt   (q_pkt),
        .out_ready (q_ready)
    );

    ips_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (q_valid),
        .pkt       (q_pkt),
        .pkt_ready (q_ready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_index (m_axis_tuser),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    assign s_axis_tready = push_ready;

    `IPS_ASSERT(a_last_on_delta, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == WORD_DELTA)), "tlast does not match the timer delta index")
    `IPS_ASSERT(a_index_steps, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && (m_axis_tuser == 5'($past(m_axis_tuser) + 5'd1))), "word index did not advance by one")
    `IPS_ASSERT_ALWAYS(a_push_taken, push |-> push_ready, "found packet pushed into a full queue")

endmodule

>>> tb/imu_packet_sync_and_extract_tb.sv
// Self-checking testbench for imu_packet_sync_and_extract: byte stream in, packet words out.
// Predicts the 19 results of every found packet and compares them with the output stream.
// Depends on ips_pkg and the imu_packet_sync_and_extract RTL.
`timescale 1ns / 1ps

module imu_packet_sync_and_extract_tb;

    import ips_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 40;

    typedef enum logic {REQ_BYTE, REQ_HEADER} request_kind_e;
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_style_e;

    typedef struct {
        request_kind_e kind;
        byte_t         value;
    } request_t;

    typedef struct packed {
        word_index_t index;
        word_t       data;
        logic        last;
    } packet_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [4:0]  m_axis_tuser;
    logic        m_axis_tlast;

    request_t     pending_requests[$];
    packet_word_t expected_words[$];
    int           errors = 0;

    byte_t rx_window [PACKET_BYTES];
    int    rx_fill = 0;
    logic [15:0] rx_sum = '0;
    word_t last_timer = '0;
    byte_t header_copy = HEADER_RESET;

    byte_t plan_header = HEADER_RESET;
    word_t plan_timer = '0;
    int    queued_bytes = 0;

    imu_packet_sync_and_extract DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    function automatic int draw_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function void absorb_byte(input byte_t b);
        word_t timer;
        rx_sum = rx_sum - {8'h00, rx_window[0]} + {8'h00, rx_window[SUM_BYTES]};
        for (int i = 0; i < PACKET_BYTES - 1; i++)
            rx_window[i] = rx_window[i + 1];
        rx_window[PACKET_BYTES - 1] = b;
        if (rx_fill < PACKET_BYTES)
            rx_fill++;
        if (rx_fill == PACKET_BYTES && rx_window[0] == header_copy &&
            {rx_window[SUM_BYTES], rx_window[SUM_BYTES + 1]} == rx_sum)
        begin
            for (int k = 0; k < PAYLOAD_WORDS; k++)
                expected_words.push_back({5'(k), rx_window[1 + 4 * k], rx_window[2 + 4 * k],
                                          rx_window[3 + 4 * k], rx_window[4 + 4 * k], 1'b0});
            timer = {rx_window[TIMER_POS], rx_window[TIMER_POS + 1],
                     rx_window[TIMER_POS + 2], rx_window[TIMER_POS + 3]};
            expected_words.push_back({WORD_DELTA, timer - last_timer, 1'b1});
            last_timer = timer;
            foreach (rx_window[i])
                rx_window[i] = '0;
            rx_fill = 0;
            rx_sum = '0;
        end
    endfunction

    function void check_word();
        packet_word_t want;
        if (expected_words.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, got index %0d data %h last %0b",
                     $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
            errors++;
            return;
        end
        want = expected_words.pop_front();
        if (m_axis_tuser !== want.index)
        begin
            $display("%0t: word_index expected %0d, got %0d", $time, want.index, m_axis_tuser);
            errors++;
        end
        if (m_axis_tdata !== want.data)
        begin
            $display("%0t: data_word expected %h, got %h", $time, want.data, m_axis_tdata);
            errors++;
        end
        if (m_axis_tlast !== want.last)
        begin
            $display("%0t: is_last expected %0b, got %0b", $time, want.last, m_axis_tlast);
            errors++;
        end
    endfunction

    task queue_byte(input byte_t b);
        pending_requests.push_back('{REQ_BYTE, b});
        queued_bytes++;
    endtask

    task queue_header(input byte_t h);
        pending_requests.push_back('{REQ_HEADER, h});
        plan_header = h;
    endtask

    task queue_packet(input byte_t head, input fill_style_e style, input word_t timer,
                      input bit spoil);
        byte_t pkt [PACKET_BYTES];
        logic [15:0] sum;
        pkt[0] = head;
        for (int i = 1; i < TIMER_POS; i++)
        begin
            case (style)
                FILL_ZERO: pkt[i] = 8'h00;
                FILL_ONES: pkt[i] = 8'hFF;
                default:   pkt[i] = 8'($urandom);
            endcase
        end
        {pkt[TIMER_POS], pkt[TIMER_POS + 1], pkt[TIMER_POS + 2], pkt[TIMER_POS + 3]} = timer;
        sum = '0;
        for (int i = 0; i < SUM_BYTES; i++)
            sum = sum + {8'h00, pkt[i]};
        {pkt[SUM_BYTES], pkt[SUM_BYTES + 1]} = sum;
        if (spoil)
            pkt[SUM_BYTES + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
        foreach (pkt[i])
            queue_byte(pkt[i]);
        plan_timer = timer;
    endtask

    task queue_random_segment();
        int pick;
        word_t timer;
        pick = $urandom_range(0, 99);
        timer = ($urandom_range(0, 1) == 1) ? plan_timer + $urandom_range(1, 5000) : $urandom;
        if (pick < 70)
            queue_packet(plan_header, FILL_RANDOM, timer, 1'b0);
        else if (pick < 80)
            queue_packet(plan_header, FILL_RANDOM, timer, 1'b1);
        else if (pick < 88)
            queue_packet(plan_header ^ 8'(1 << $urandom_range(0, 7)), FILL_RANDOM, timer, 1'b0);
        else
            repeat ($urandom_range(1, 30))
                queue_byte(($urandom_range(0, 3) == 0) ? plan_header : 8'($urandom));
    endtask

    // Request driver: bytes from the pending queue, header writes only once the output is idle.
    int    gap_left = 0;
    int    settle = 0;
    bit    in_calm = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        request_t item;
        logic     next_valid;
        logic [7:0] next_data;
        logic     next_we;
        logic [7:0] next_wdata;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            cfg_we        <= 1'b0;
            cfg_wdata     <= '0;
            gap_left = 0;
            settle = 0;
        end
        else
        begin
            next_valid = s_axis_tvalid;
            next_data  = s_axis_tdata;
            next_we    = 1'b0;
            next_wdata = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_byte(s_axis_tdata);
                next_valid = 1'b0;
            end
            settle = (expected_words.size() == 0 && !s_axis_tvalid) ? settle + 1 : 0;
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_requests.size() != 0)
                begin
                    if (pending_requests[0].kind == REQ_HEADER)
                    begin
                        if (settle >= SETTLE_CYCLES)
                        begin
                            item = pending_requests.pop_front();
                            next_we = 1'b1;
                            next_wdata = item.value;
                            header_copy = item.value;
                            settle = 0;
                        end
                    end
                    else
                    begin
                        item = pending_requests.pop_front();
                        next_valid = 1'b1;
                        next_data = item.value;
                        if ($urandom_range(0, 99) < 3)
                            in_calm = !in_calm;
                        gap_left = in_calm ? 0 : draw_pause();
                    end
                end
            end
            s_axis_tvalid <= next_valid;
            s_axis_tdata  <= next_data;
            cfg_we        <= next_we;
            cfg_wdata     <= next_wdata;
        end
    end

    // Result monitor with random back-pressure.
    int stall_left = 0;
    bit out_calm = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_word();
            if ($urandom_range(0, 99) < 2)
                out_calm = !out_calm;
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                stall_left = out_calm ? 0 : draw_pause();
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        int target;
        foreach (rx_window[i])
            rx_window[i] = '0;

        repeat (5)
            queue_byte(8'($urandom));
        queue_packet(plan_header, FILL_RANDOM, 32'h0000_0010, 1'b1);
        queue_packet(plan_header, FILL_ONES, 32'hFFFF_FFFF, 1'b0);
        queue_packet(plan_header, FILL_RANDOM, 32'h0000_0005, 1'b0);
        queue_header(8'h00);
        queue_packet(8'h00, FILL_ZERO, 32'h8000_0000, 1'b0);

        queue_header(8'($urandom));
        target = queued_bytes + 30;
        while (queued_bytes < target)
            queue_random_segment();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && expected_words.size() == 0)
            $display("imu_packet_sync_and_extract_tb: PASS");
        else
            $display("imu_packet_sync_and_extract_tb: FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("imu_packet_sync_and_extract_tb: FAIL");
        $finish;
    end

endmodule
